>>> sv/interpolating_audio_delay_line_unit_defines.svh
// Assertion macros for the delay line unit
`ifndef INTERPOLATING_AUDIO_DELAY_LINE_UNIT_DEFINES_SVH
`define INTERPOLATING_AUDIO_DELAY_LINE_UNIT_DEFINES_SVH

// condition implies consequence in the same cycle
`define IADL_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("iadl: implication check failed");

// condition implies consequence in the next cycle
`define IADL_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("iadl: next-cycle check failed");

`endif

>>> sv/iadl_pkg.sv
package iadl_pkg;

   localparam int DEPTH_DEF       = 16384;
   localparam int SAMPLE_BITS_DEF = 24;
   localparam int FRAC_BITS_DEF   = 16;

   localparam int MODE_BITS  = 3;
   localparam int IDX_BITS   = 32;
   localparam int AGO_BITS   = 31;
   localparam int CSR_BITS   = 15;
   localparam int LEN_RESET  = 16384;

   // signed dividend seen by the index reduction unit
   localparam int DIV_BITS   = 33;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_RING_WR  = 3'd0,
      MODE_READ_AGO = 3'd1,
      MODE_ABS_WR   = 3'd2,
      MODE_ABS_RD   = 3'd3,
      MODE_LINEAR   = 3'd4,
      MODE_HERMITE  = 3'd5
   } mode_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mod_status_type;

endpackage

>>> sv/iadl_mod.sv
module iadl_mod #(
   parameter int LEN_BITS  = 15,
   parameter int ADDR_BITS = 14
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [iadl_pkg::DIV_BITS-1:0] dividend,
   input  logic [LEN_BITS-1:0]                  len,
   output logic [ADDR_BITS-1:0]                 result,
   output iadl_pkg::mod_status_type             status
);
   import iadl_pkg::*;

   localparam int CNT_BITS = $clog2(DIV_BITS + 1);

   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic                 neg_ff, neg_in;
   logic [DIV_BITS-1:0]  mag_ff, mag_in;
   logic [LEN_BITS-1:0]  rem_ff, rem_in;
   logic [ADDR_BITS-1:0] res_ff, res_in;

   logic [LEN_BITS:0]    shifted;
   logic [LEN_BITS-1:0]  rem_nx;
   logic [LEN_BITS-1:0]  fixed;

   // restoring step: one dividend bit a cycle
   always_comb begin
      shifted = {rem_ff, mag_ff[DIV_BITS-1]};
      if (shifted >= {1'b0, len}) begin
         rem_nx = LEN_BITS'(shifted - {1'b0, len});
      end else begin
         rem_nx = LEN_BITS'(shifted);
      end
      if (neg_ff && (rem_nx != '0)) begin
         fixed = len - rem_nx;
      end else begin
         fixed = rem_nx;
      end
   end

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      if (start) begin
         cnt_in = CNT_BITS'(DIV_BITS);
         neg_in = dividend[DIV_BITS-1];
         mag_in = dividend[DIV_BITS-1] ? DIV_BITS'(-dividend) : DIV_BITS'(dividend);
         rem_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         mag_in = {mag_ff[DIV_BITS-2:0], 1'b0};
         rem_in = rem_nx;
         if (cnt_ff == CNT_BITS'(1)) begin
            done_in = 1'b1;
            res_in  = ADDR_BITS'(fixed);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
   end

   assign result      = res_ff;
   assign status.busy = (cnt_ff != '0);
   assign status.done = done_ff;

endmodule

>>> sv/interpolating_audio_delay_line_unit.sv
// Every mode runs the bit-serial index reduction (33 steps, one bit a cycle); reads fetch their
// samples through one memory read port, each sample in a FETCH and a LATCH state. One word is
// handled at a time: the next word is taken after the result.
// A finished result sits in the output register while the next word is taken.
// Reset is synchronous: after it a clearing pass zeroes every word of the store (DEPTH, 16384 by
// default), during which no word is taken; length is 16384 and the write pointer zero.
`include "interpolating_audio_delay_line_unit_defines.svh"

module interpolating_audio_delay_line_unit #(
   parameter int DEPTH       = iadl_pkg::DEPTH_DEF,
   parameter int SAMPLE_BITS = iadl_pkg::SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = iadl_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [iadl_pkg::CSR_BITS-1:0]        csr_wr_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [iadl_pkg::MODE_BITS-1:0]       req_mode,
   input  logic signed [SAMPLE_BITS-1:0]        req_sample_in,
   input  logic signed [iadl_pkg::IDX_BITS-1:0] req_index,
   input  logic [iadl_pkg::AGO_BITS-1:0]        req_samples_ago,
   input  logic [FRAC_BITS-1:0]                 req_frac,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]        rsp_sample_out,
   output logic                                 rsp_is_read
);
   import iadl_pkg::*;

   localparam int AW       = $clog2(DEPTH);
   localparam int LEN_BITS = $clog2(DEPTH + 1);
   localparam int ACC_BITS = SAMPLE_BITS + 6;
   localparam int P        = ACC_BITS + FRAC_BITS + 1;

   localparam logic signed [P:0] HALF_F  = (P+1)'(64'sd1 <<< (FRAC_BITS - 1));
   localparam logic signed [P:0] HALF_F1 = (P+1)'(64'sd1 <<< FRAC_BITS);
   localparam logic signed [ACC_BITS:0] SAT_HI =
      (ACC_BITS+1)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [ACC_BITS:0] SAT_LO = -SAT_HI - 1;

   localparam logic [1:0] STEP_A = 2'd0;
   localparam logic [1:0] STEP_B = 2'd1;
   localparam logic [1:0] STEP_Y = 2'd2;

   typedef enum logic [8:0] {
      ST_CLEAR = 9'b000000001,
      ST_IDLE  = 9'b000000010,
      ST_MOD   = 9'b000000100,
      ST_FETCH = 9'b000001000,
      ST_LATCH = 9'b000010000,
      ST_COEF  = 9'b000100000,
      ST_MUL   = 9'b001000000,
      ST_ADD   = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

   state_type                   state_ff, state_in;
   logic [AW-1:0]               clr_cnt_ff, clr_cnt_in;
   logic [AW-1:0]               wp_ff, wp_in;
   logic [CSR_BITS-1:0]         len_ff, len_in;
   mode_type                    mode_ff, mode_in;
   logic [SAMPLE_BITS-1:0]      smp_ff, smp_in;
   logic [FRAC_BITS-1:0]        t_ff, t_in;
   logic [AW-1:0]               addr_ff, addr_in;
   logic [1:0]                  tcnt_ff, tcnt_in;
   logic [1:0]                  tlast_ff, tlast_in;
   logic signed [SAMPLE_BITS-1:0] tap_ff [4];
   logic signed [SAMPLE_BITS-1:0] tap_in [4];
   logic signed [ACC_BITS-1:0]  acc_ff, acc_in;
   logic signed [ACC_BITS-1:0]  ca_ff, ca_in;
   logic signed [ACC_BITS-1:0]  cb_ff, cb_in;
   logic signed [SAMPLE_BITS-1:0] base_ff, base_in;
   logic signed [P-1:0]         prod_ff, prod_in;
   logic [1:0]                  step_ff, step_in;
   logic signed [SAMPLE_BITS-1:0] y_ff, y_in;
   logic                        isr_ff, isr_in;
   logic                        out_valid_ff, out_valid_in;
   logic signed [SAMPLE_BITS-1:0] out_sample_ff, out_sample_in;
   logic                        out_read_ff, out_read_in;

   logic [SAMPLE_BITS-1:0]      mem [DEPTH];
   logic [SAMPLE_BITS-1:0]      rd_data_ff;
   logic                        mem_we;
   logic [AW-1:0]               mem_wa;
   logic [SAMPLE_BITS-1:0]      mem_wd;

   logic [LEN_BITS-1:0]         eff_len;
   logic [31:0]                 len_wide;
   logic                        mod_start;
   logic signed [DIV_BITS-1:0]  dividend;
   logic [AW-1:0]               mod_res;
   mod_status_type              mod_st;

   logic signed [FRAC_BITS:0]   t_x;
   logic signed [P:0]           prod_x;
   logic signed [P:0]           rnd_f;
   logic signed [P:0]           rnd_y;
   logic signed [ACC_BITS:0]    y_sum;
   logic signed [ACC_BITS:0]    y_sat;
   logic signed [ACC_BITS-1:0]  sx_m1, sx_0, sx_1, sx_2;

   function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a,
                                              input logic [LEN_BITS-1:0] l);
      logic [LEN_BITS-1:0] nx;
      nx = LEN_BITS'(a) + LEN_BITS'(1);
      return (nx == l) ? '0 : AW'(nx);
   endfunction

   function automatic logic [AW-1:0] addr_dec(input logic [AW-1:0] a,
                                              input logic [LEN_BITS-1:0] l);
      return (a == '0) ? AW'(l - LEN_BITS'(1)) : a - AW'(1);
   endfunction

   // length 0 behaves as 1, beyond the store as the full store
   always_comb begin
      len_wide = 32'(len_ff);
      if (len_wide == 32'd0) begin
         eff_len = LEN_BITS'(1);
      end else if (len_wide > 32'(DEPTH)) begin
         eff_len = LEN_BITS'(DEPTH);
      end else begin
         eff_len = LEN_BITS'(len_wide);
      end
   end

   always_comb begin
      unique case (mode_type'(req_mode))
         MODE_RING_WR:  dividend = DIV_BITS'(wp_ff);
         MODE_READ_AGO: dividend = DIV_BITS'(wp_ff) - DIV_BITS'(1)
                                   - DIV_BITS'(req_samples_ago);
         default:       dividend = DIV_BITS'(req_index);
      endcase
   end

   iadl_mod #(
      .LEN_BITS  (LEN_BITS),
      .ADDR_BITS (AW)
   ) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (dividend),
      .len      (eff_len),
      .result   (mod_res),
      .status   (mod_st)
   );

   // shared multiplier and rounding
   always_comb begin
      t_x    = $signed({1'b0, t_ff});
      prod_x = $signed({prod_ff[P-1], prod_ff});
      rnd_f  = (prod_x + HALF_F) >>> FRAC_BITS;
      if (mode_ff == MODE_HERMITE) begin
         rnd_y = (prod_x + HALF_F1) >>> (FRAC_BITS + 1);
      end else begin
         rnd_y = rnd_f;
      end
      y_sum = (ACC_BITS+1)'(base_ff) + (ACC_BITS+1)'(ACC_BITS'(rnd_y));
      if (y_sum > SAT_HI) begin
         y_sat = SAT_HI;
      end else if (y_sum < SAT_LO) begin
         y_sat = SAT_LO;
      end else begin
         y_sat = y_sum;
      end
      sx_m1 = ACC_BITS'(tap_ff[0]);
      sx_0  = ACC_BITS'(tap_ff[1]);
      sx_1  = ACC_BITS'(tap_ff[2]);
      sx_2  = ACC_BITS'(tap_ff[3]);
   end

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      wp_in         = wp_ff;
      len_in        = len_ff;
      mode_in       = mode_ff;
      smp_in        = smp_ff;
      t_in          = t_ff;
      addr_in       = addr_ff;
      tcnt_in       = tcnt_ff;
      tlast_in      = tlast_ff;
      tap_in        = tap_ff;
      acc_in        = acc_ff;
      ca_in         = ca_ff;
      cb_in         = cb_ff;
      base_in       = base_ff;
      prod_in       = prod_ff;
      step_in       = step_ff;
      y_in          = y_ff;
      isr_in        = isr_ff;
      out_valid_in  = out_valid_ff;
      out_sample_in = out_sample_ff;
      out_read_in   = out_read_ff;
      mem_we        = 1'b0;
      mem_wa        = clr_cnt_ff;
      mem_wd        = '0;
      mod_start     = 1'b0;

      if (csr_wr_en) begin
         len_in = csr_wr_data;
      end
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               mode_in = mode_type'(req_mode);
               smp_in  = req_sample_in;
               t_in    = req_frac;
               y_in    = '0;
               isr_in  = 1'b0;
               if (req_mode <= MODE_BITS'(MODE_HERMITE)) begin
                  mod_start = 1'b1;
                  state_in  = ST_MOD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MOD: begin
            if (mod_st.done) begin
               addr_in = mod_res;
               tcnt_in = '0;
               mem_wa  = mod_res;
               mem_wd  = smp_ff;
               unique case (mode_ff)
                  MODE_RING_WR: begin
                     mem_we   = 1'b1;
                     wp_in    = addr_inc(mod_res, eff_len);
                     state_in = ST_DONE;
                  end
                  MODE_ABS_WR: begin
                     mem_we   = 1'b1;
                     state_in = ST_DONE;
                  end
                  MODE_READ_AGO, MODE_ABS_RD: begin
                     tlast_in = 2'd0;
                     state_in = ST_FETCH;
                  end
                  MODE_LINEAR: begin
                     tlast_in = 2'd1;
                     state_in = ST_FETCH;
                  end
                  MODE_HERMITE: begin
                     addr_in  = addr_dec(mod_res, eff_len);
                     tlast_in = 2'd3;
                     state_in = ST_FETCH;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_FETCH: begin
            state_in = ST_LATCH;
         end
         ST_LATCH: begin
            tap_in[0] = tap_ff[1];
            tap_in[1] = tap_ff[2];
            tap_in[2] = tap_ff[3];
            tap_in[3] = rd_data_ff;
            tcnt_in   = tcnt_ff + 2'd1;
            addr_in   = addr_inc(addr_ff, eff_len);
            if (tcnt_ff == tlast_ff) begin
               isr_in = 1'b1;
               if (mode_ff == MODE_READ_AGO || mode_ff == MODE_ABS_RD) begin
                  y_in     = rd_data_ff;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_COEF;
               end
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_COEF: begin
            if (mode_ff == MODE_HERMITE) begin
               ca_in   = sx_1 - sx_m1;
               cb_in   = (sx_m1 <<< 1) - (sx_0 <<< 2) - sx_0 + (sx_1 <<< 2) - sx_2;
               acc_in  = (sx_2 - sx_m1) + ((sx_0 - sx_1) <<< 1) + (sx_0 - sx_1);
               base_in = tap_ff[1];
               step_in = STEP_A;
            end else begin
               // linear: taps hold x0 then x1 at the top of the line
               acc_in  = sx_2 - sx_1;
               base_in = tap_ff[2];
               step_in = STEP_Y;
            end
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = acc_ff * t_x;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            case (step_ff)
               STEP_A: begin
                  acc_in   = cb_ff + ACC_BITS'(rnd_f);
                  step_in  = STEP_B;
                  state_in = ST_MUL;
               end
               STEP_B: begin
                  acc_in   = ca_ff + ACC_BITS'(rnd_f);
                  step_in  = STEP_Y;
                  state_in = ST_MUL;
               end
               default: begin
                  y_in     = SAMPLE_BITS'(y_sat);
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_DONE: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_valid_in  = 1'b1;
               out_sample_in = y_ff;
               out_read_in   = isr_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         wp_ff        <= '0;
         len_ff       <= CSR_BITS'(LEN_RESET);
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         wp_ff        <= wp_in;
         len_ff       <= len_in;
         out_valid_ff <= out_valid_in;
      end
      mode_ff       <= mode_in;
      smp_ff        <= smp_in;
      t_ff          <= t_in;
      addr_ff       <= addr_in;
      tcnt_ff       <= tcnt_in;
      tlast_ff      <= tlast_in;
      tap_ff        <= tap_in;
      acc_ff        <= acc_in;
      ca_ff         <= ca_in;
      cb_ff         <= cb_in;
      base_ff       <= base_in;
      prod_ff       <= prod_in;
      step_ff       <= step_in;
      y_ff          <= y_in;
      isr_ff        <= isr_in;
      out_sample_ff <= out_sample_in;
      out_read_ff   <= out_read_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = out_valid_ff;
   assign rsp_sample_out = out_sample_ff;
   assign rsp_is_read    = out_read_ff;

   `IADL_ASSERT_IMP(a_mod_in_range, clock, reset, mod_st.done,
                    LEN_BITS'(mod_res) < eff_len)
   `IADL_ASSERT_NXT(a_wp_in_range, clock, reset,
                    state_ff == ST_MOD && mod_st.done && mode_ff == MODE_RING_WR,
                    LEN_BITS'(wp_ff) < eff_len)
   `IADL_ASSERT_NXT(a_start_mod, clock, reset,
                    req_valid && !req_stall && req_mode <= MODE_BITS'(MODE_HERMITE),
                    mod_st.busy)
   `IADL_ASSERT_IMP(a_rsp_from_done, clock, reset, $rose(rsp_valid),
                    $past(state_ff == ST_DONE))
   `IADL_ASSERT_NXT(a_clear_exit, clock, reset, state_ff == ST_CLEAR,
                    state_ff == ST_CLEAR || state_ff == ST_IDLE)

endmodule
